// ===== hw/rtl/pixel_blend_raster_op_assert.svh =====
// Assertion macros for the pixel blend raster operation checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PIXEL_BLEND_RASTER_OP_ASSERT_SVH
`define PIXEL_BLEND_RASTER_OP_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define PBRO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define PBRO_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PBRO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pbro_pkg.sv =====
// Shared types and constants for the pixel blend raster operation.
// Used by every stage module, the top level and the checker; depends on nothing.
package pbro_pkg;

  localparam int unsigned PIX_W     = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIPE_DEPTH = 3;

  localparam logic [PIX_W-1:0] PIX_MASK_24 = 24'hFF_FFFF;
  localparam logic [PIX_W-1:0] PIX_MASK_16 = 24'h00_FFFF;

  // RGB565 channels spread over a 32-bit word: green high, red and blue low.
  localparam logic [31:0] SPREAD_MASK  = 32'b00000111111000001111100000011111;
  localparam logic [7:0]  ALPHA_FULL   = 8'd255;
  localparam logic [8:0]  A5_ROUND     = 9'd4;
  localparam int unsigned A5_SHIFT     = 3;
  localparam int unsigned MIX565_SHIFT = 5;
  localparam int unsigned HI_SHIFT     = 16;
  localparam int unsigned DIV255_SHIFT = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR    = 2'd3;

  typedef enum logic [1:0] {
    MODE_XOR   = 2'd0,
    MODE_XNOR  = 2'd1,
    MODE_KEY   = 2'd2,
    MODE_ALPHA = 2'd3
  } blend_mode_t;

  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_RGB24  = 1'b1
  } pix_fmt_t;

  // Which datapath produces the final pixel.
  typedef enum logic [1:0] {
    SEL_DIRECT = 2'd0,
    SEL_MIX565 = 2'd1,
    SEL_MIX24  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;
    logic             last_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] result_pixel;
    logic             last_out;
  } out_item_t;

  typedef struct packed {
    blend_mode_t      mode;
    pix_fmt_t         fmt;
    logic [7:0]       alpha;
    logic [PIX_W-1:0] key;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dst;
    logic [31:0]      diff565;
    logic [31:0]      bg565;
    logic [PIX_W-1:0] direct;
    res_sel_t         sel;
    logic             last;
  } prep_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][15:0] prod_fg;
    logic [NUM_CHAN-1:0][15:0] prod_bg;
    logic [31:0]               prod565;
    logic [31:0]               bg565;
    logic [PIX_W-1:0]          direct;
    res_sel_t                  sel;
    logic                      last;
  } mul_t;

endpackage

// ===== hw/rtl/pbro_prep.sv =====
// First stage: masks the pixels to the format, resolves the non-blending modes
// and spreads RGB565 pixels for the packed blend. Depends on pbro_pkg.
module pbro_prep
  import pbro_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output prep_t    data_o
);

  logic             valid_r;
  prep_t            prep_r;
  prep_t            prep_nxt;
  logic             rgb24;
  logic [PIX_W-1:0] pmask;
  logic [PIX_W-1:0] src;
  logic [PIX_W-1:0] dst;
  logic             key_hit;
  logic [31:0]      fg565;
  logic [31:0]      bg565;

  always_comb begin
    rgb24 = (cfg.fmt == FMT_RGB24);
    pmask = rgb24 ? PIX_MASK_24 : PIX_MASK_16;
    src   = data_i.src_pixel & pmask;
    dst   = data_i.dst_pixel & pmask;
    key_hit = rgb24 &&
              (src[7:0]   <= cfg.key[7:0]) &&
              (src[15:8]  <= cfg.key[15:8]) &&
              (src[23:16] <= cfg.key[23:16]);
    fg565 = {src[15:0], src[15:0]} & SPREAD_MASK;
    bg565 = {dst[15:0], dst[15:0]} & SPREAD_MASK;

    prep_nxt.src     = src;
    prep_nxt.dst     = dst;
    prep_nxt.diff565 = fg565 - bg565;
    prep_nxt.bg565   = bg565;
    prep_nxt.last    = data_i.last_in;
    prep_nxt.sel     = SEL_DIRECT;
    prep_nxt.direct  = dst;
    case (cfg.mode)
      MODE_XOR: begin
        prep_nxt.direct = src ^ dst;
      end
      MODE_XNOR: begin
        prep_nxt.direct = (dst ^ ~src) & pmask;
      end
      MODE_KEY: begin
        prep_nxt.direct = key_hit ? src : dst;
      end
      MODE_ALPHA: begin
        if (cfg.alpha == 8'd0) begin
          prep_nxt.direct = dst;
        end else if (cfg.alpha == ALPHA_FULL) begin
          prep_nxt.direct = src;
        end else begin
          prep_nxt.sel = rgb24 ? SEL_MIX24 : SEL_MIX565;
        end
      end
      default: begin
        prep_nxt.direct = dst;
      end
    endcase
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      prep_r <= prep_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = prep_r;

endmodule

// ===== hw/rtl/pbro_mul.sv =====
// Second stage: the per-channel 8x8 products of the RGB24 blend and the
// 32x6 product of the packed RGB565 blend. Depends on pbro_pkg.
module pbro_mul
  import pbro_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  valid_i,
  output logic  ready_o,
  input  prep_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output mul_t  data_o
);

  logic        valid_r;
  mul_t        mul_r;
  mul_t        mul_nxt;
  logic [8:0]  a_sum;
  logic [8:0]  a_scaled;
  logic [5:0]  a5;
  logic [7:0]  inv_alpha;

  always_comb begin
    // Alpha reduced to 0..32 for the packed blend.
    a_sum     = {1'b0, cfg.alpha} + A5_ROUND;
    a_scaled  = a_sum >> A5_SHIFT;
    a5        = a_scaled[5:0];
    inv_alpha = ALPHA_FULL - cfg.alpha;

    for (int c = 0; c < NUM_CHAN; c++) begin
      mul_nxt.prod_fg[c] = {8'd0, cfg.alpha} * {8'd0, data_i.src[c*CHAN_W +: CHAN_W]};
      mul_nxt.prod_bg[c] = {8'd0, inv_alpha} * {8'd0, data_i.dst[c*CHAN_W +: CHAN_W]};
    end
    mul_nxt.prod565 = data_i.diff565 * {26'd0, a5};
    mul_nxt.bg565   = data_i.bg565;
    mul_nxt.direct  = data_i.direct;
    mul_nxt.sel     = data_i.sel;
    mul_nxt.last    = data_i.last;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      mul_r <= mul_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = mul_r;

endmodule

// ===== hw/rtl/pbro_mix.sv =====
// Third stage and output register: sums the products, divides the RGB24
// channels by 255, finishes the RGB565 blend and picks the result. Depends on pbro_pkg.
module pbro_mix
  import pbro_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  output logic      ready_o,
  input  mul_t      data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t data_o
);

  logic             valid_r;
  out_item_t        out_r;
  out_item_t        out_nxt;
  logic [31:0]      r565;
  logic [31:0]      r565_hi;
  logic [15:0]      res565;
  logic [16:0]      chan_sum;
  logic [16:0]      chan_q;
  logic [PIX_W-1:0] res24;

  always_comb begin
    r565    = ((data_i.prod565 >> MIX565_SHIFT) + data_i.bg565) & SPREAD_MASK;
    r565_hi = r565 >> HI_SHIFT;
    res565  = r565_hi[15:0] | r565[15:0];

    res24    = '0;
    chan_sum = '0;
    chan_q   = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_sum = {1'b0, data_i.prod_fg[c]} + {1'b0, data_i.prod_bg[c]};
      // Exact floor(x / 255) for x below 65535.
      chan_q   = (chan_sum + (chan_sum >> DIV255_SHIFT) + 17'd1) >> DIV255_SHIFT;
      res24[c*CHAN_W +: CHAN_W] = chan_q[CHAN_W-1:0];
    end

    out_nxt.last_out = data_i.last;
    case (data_i.sel)
      SEL_MIX565: out_nxt.result_pixel = {8'd0, res565};
      SEL_MIX24:  out_nxt.result_pixel = res24;
      default:    out_nxt.result_pixel = data_i.direct;
    endcase
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      out_r <= out_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = out_r;

endmodule

// ===== hw/rtl/pixel_blend_raster_op.sv =====
// Pixel blend raster operation: combines a source and a destination pixel into
// a new destination pixel (XOR, XNOR, RGB24 color key or alpha blend, in RGB565
// or RGB24), taking one pixel per clock unless the output stalls. Each request passes
// three register stages (prepare, multiply, sum and divide); the last stage is the
// output register. Up to three pixels are in flight, and in_ready follows out_ready
// through the stage occupancy, so the block keeps accepting while any stage is free.
// Configuration writes take effect at once and are meant for when no pixel is in
// flight; cfg_ready is always high.
module pixel_blend_raster_op
  import pbro_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  cfg_t  cfg_r;
  logic  prep_valid;
  logic  prep_ready;
  prep_t prep_data;
  logic  mul_valid;
  logic  mul_ready;
  mul_t  mul_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_ALPHA;
      cfg_r.fmt   <= FMT_RGB565;
      cfg_r.alpha <= ALPHA_FULL;
      cfg_r.key   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLEND_MODE:   cfg_r.mode  <= blend_mode_t'(cfg_data[1:0]);
        CFG_PIXEL_FORMAT: cfg_r.fmt   <= pix_fmt_t'(cfg_data[0]);
        CFG_ALPHA_LEVEL:  cfg_r.alpha <= cfg_data[7:0];
        CFG_KEY_COLOR:    cfg_r.key   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pbro_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .data_i  (in_data),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .data_o  (prep_data)
  );

  pbro_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  pbro_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .data_o  (out_data)
  );

endmodule

// ===== hw/rtl/pbro_checker.sv =====
// Port-level checker for the pixel blend raster operation, bound to the top level.
// Depends on pbro_pkg and the assertion macros header.
`include "pixel_blend_raster_op_assert.svh"

module pbro_checker
  import pbro_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_item_t            out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [PIX_W-1:0]     cfg_data
);

  pix_fmt_t   fmt_r;
  logic [2:0] occ_r;
  logic [2:0] occ_nxt;
  logic       out_stall;
  logic       is565_out;
  logic [7:0] upper_byte;
  logic       occ_ok;

  // Shadow of the format register, seen through the write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB565;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_PIXEL_FORMAT) begin
      fmt_r <= pix_fmt_t'(cfg_data[0]);
    end
  end

  // Requests accepted but not yet delivered.
  always_comb begin
    occ_nxt = occ_r + {2'd0, in_valid && in_ready} - {2'd0, out_valid && out_ready};
    out_stall  = out_valid && !out_ready;
    is565_out  = out_valid && (fmt_r == FMT_RGB565);
    upper_byte = out_data.result_pixel[23:16];
    occ_ok     = (occ_r <= 3'(PIPE_DEPTH)) && (!out_valid || occ_r != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `PBRO_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled result changed")
  `PBRO_ASSERT_IMPL(a_rgb565_upper_zero, is565_out, upper_byte == 8'd0, "RGB565 upper byte set")
  `PBRO_ASSERT_IMPL(a_ready_when_drained, !out_valid, in_ready, "input stalled on empty output")
  `PBRO_ASSERT(a_occupancy, occ_ok, "pipeline occupancy out of range")

endmodule

bind pixel_blend_raster_op pbro_checker u_pbro_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for pixel_blend_raster_op: streams pixel requests under many
// blend settings and checks every result against an in-bench blend predictor.
// Depends on pbro_pkg and the pixel_blend_raster_op top level.
module testbench
  import pbro_pkg::*;
();

  localparam int STALL_LIMIT = 500;
  localparam int NUM_PHASES = 30;
  localparam int PHASE_LEN = 50;

  // Holds the blend registers and the pixels still owed by the block.
  class pixel_scoreboard;
    blend_mode_t mode;
    pix_fmt_t    fmt;
    logic [7:0]  alpha;
    logic [23:0] key;
    out_item_t   expected_pixels[$];
    int          errors;

    function new();
      mode = MODE_ALPHA;
      fmt = FMT_RGB565;
      alpha = ALPHA_FULL;
      key = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
      case (idx)
        CFG_BLEND_MODE:   mode = blend_mode_t'(data[1:0]);
        CFG_PIXEL_FORMAT: fmt = pix_fmt_t'(data[0]);
        CFG_ALPHA_LEVEL:  alpha = data[7:0];
        CFG_KEY_COLOR:    key = data;
        default: ;
      endcase
    endfunction

    // Channels are spread so green sits in the high half; the whole word wraps at 32 bits.
    function logic [15:0] mix565(logic [15:0] s, logic [15:0] d);
      logic [31:0] a5, fg, bg, acc;
      a5 = ({24'd0, alpha} + 32'd4) >> 3;
      bg = {d, d} & SPREAD_MASK;
      fg = {s, s} & SPREAD_MASK;
      acc = (fg - bg) * a5;
      acc = acc >> 5;
      acc = acc + bg;
      acc = acc & SPREAD_MASK;
      return acc[31:16] | acc[15:0];
    endfunction

    function logic [7:0] mix_channel(logic [7:0] f, logic [7:0] b);
      int unsigned a, sum;
      a = alpha;
      sum = a * f + (255 - a) * b;
      return 8'(sum / 255);
    endfunction

    function out_item_t blend_pixel(in_item_t req);
      out_item_t   res;
      logic [23:0] pmask, src, dst, pix;
      logic        is24;
      is24 = (fmt == FMT_RGB24);
      pmask = is24 ? PIX_MASK_24 : PIX_MASK_16;
      src = req.src_pixel & pmask;
      dst = req.dst_pixel & pmask;
      case (mode)
        MODE_XOR:  pix = src ^ dst;
        MODE_XNOR: pix = dst ^ ~src;
        MODE_KEY: begin
          // The key only applies in RGB24; RGB565 keeps the destination.
          if (is24 && src[7:0] <= key[7:0] && src[15:8] <= key[15:8] &&
              src[23:16] <= key[23:16])
            pix = src;
          else
            pix = dst;
        end
        default: begin
          if (alpha == 8'd0)
            pix = dst;
          else if (alpha == ALPHA_FULL)
            pix = src;
          else if (!is24)
            pix = {8'd0, mix565(src[15:0], dst[15:0])};
          else begin
            pix[7:0]   = mix_channel(src[7:0], dst[7:0]);
            pix[15:8]  = mix_channel(src[15:8], dst[15:8]);
            pix[23:16] = mix_channel(src[23:16], dst[23:16]);
          end
        end
      endcase
      res.result_pixel = pix & pmask;
      res.last_out = req.last_in;
      return res;
    endfunction

    function void note_request(in_item_t req);
      expected_pixels.push_back(blend_pixel(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result pixel %h last %b", $time,
                 got.result_pixel, got.last_out);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.result_pixel !== want.result_pixel) begin
        $display("%0t: result_pixel expected %h got %h", $time,
                 want.result_pixel, got.result_pixel);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %b got %b", $time, want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PIX_W-1:0]     cfg_data = '0;

  pixel_scoreboard board;
  logic send_burst = 1'b0;
  logic recv_burst = 1'b0;
  int   idle_cycles = 0;
  logic [7:0] alpha_corners [11] = '{8'd1, 8'd3, 8'd4, 8'd5, 8'd11, 8'd12, 8'd127,
                                     8'd128, 8'd251, 8'd252, 8'd254};

  pixel_blend_raster_op dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Any accepted request, result or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls before each result, none during burst stretches.
  initial begin
    int stall;
    while (!rst_n) @(negedge clk);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(6, 0);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
      @(negedge clk);
    end
  end

  task automatic send_pixel(in_item_t req);
    int gap;
    gap = send_burst ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic push(logic [23:0] s, logic [23:0] d, logic l);
    in_item_t req;
    req.src_pixel = s;
    req.dst_pixel = d;
    req.last_in = l;
    send_pixel(req);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (board.expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers change only with nothing in flight; unused upper bits carry noise.
  task automatic configure(blend_mode_t m, pix_fmt_t f, logic [7:0] a, logic [23:0] k);
    logic [23:0] noise;
    drain();
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    noise = 24'($urandom);
    write_cfg(CFG_BLEND_MODE, {noise[23:2], m});
    write_cfg(CFG_PIXEL_FORMAT, {noise[22:0], f});
    write_cfg(CFG_ALPHA_LEVEL, {noise[15:0], a});
    write_cfg(CFG_KEY_COLOR, k);
    cfg_valid = 1'b0;
  endtask

  task automatic run_directed();
    // Reset state is opaque alpha in RGB565, so the upper source byte must vanish.
    push(24'hFFFFFF, 24'h000000, 1'b1);
    configure(MODE_XOR, FMT_RGB565, ALPHA_FULL, 24'h0);
    push(24'hFFFFFF, 24'h5A5A5A, 1'b0);
    push(24'h000000, 24'hFFFFFF, 1'b1);
    configure(MODE_XNOR, FMT_RGB565, ALPHA_FULL, 24'h0);
    push(24'h000000, 24'h000000, 1'b0);
    push(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    configure(MODE_XOR, FMT_RGB24, ALPHA_FULL, 24'h0);
    push(24'hFFFFFF, 24'h000000, 1'b1);
    configure(MODE_XNOR, FMT_RGB24, ALPHA_FULL, 24'h0);
    push(24'h123456, 24'h000000, 1'b0);
    configure(MODE_KEY, FMT_RGB565, ALPHA_FULL, 24'hFFFFFF);
    push(24'h000000, 24'hABCDEF, 1'b1);
    configure(MODE_KEY, FMT_RGB24, ALPHA_FULL, 24'hC04080);
    push(24'hC04080, 24'h111111, 1'b0);
    push(24'hC14080, 24'h222222, 1'b0);
    push(24'h004100, 24'h333333, 1'b0);
    push(24'h000000, 24'h444444, 1'b1);
    configure(MODE_KEY, FMT_RGB24, ALPHA_FULL, 24'h000000);
    push(24'h000000, 24'h555555, 1'b0);
    push(24'h000001, 24'h666666, 1'b1);
    configure(MODE_ALPHA, FMT_RGB565, 8'd0, 24'hFFFFFF);
    push(24'hFFFFFF, 24'h001234, 1'b0);
    configure(MODE_ALPHA, FMT_RGB565, 8'd3, 24'h0);
    push(24'h00FFFF, 24'h000000, 1'b0);
    configure(MODE_ALPHA, FMT_RGB565, 8'd128, 24'h0);
    push(24'h00FFFF, 24'h000000, 1'b0);
    push(24'h000000, 24'h00FFFF, 1'b1);
    configure(MODE_ALPHA, FMT_RGB565, 8'd252, 24'h0);
    push(24'h00F81F, 24'h0007E0, 1'b0);
    configure(MODE_ALPHA, FMT_RGB24, 8'd0, 24'h0);
    push(24'hFFFFFF, 24'h010203, 1'b0);
    configure(MODE_ALPHA, FMT_RGB24, ALPHA_FULL, 24'h0);
    push(24'h804020, 24'h010203, 1'b1);
    configure(MODE_ALPHA, FMT_RGB24, 8'd1, 24'h0);
    push(24'hFFFFFF, 24'h000000, 1'b0);
    configure(MODE_ALPHA, FMT_RGB24, 8'd254, 24'h0);
    push(24'h000000, 24'hFFFFFF, 1'b0);
    configure(MODE_ALPHA, FMT_RGB24, 8'd128, 24'h0);
    push(24'h804020, 24'h10F0FF, 1'b1);
  endtask

  function automatic in_item_t random_pixel();
    in_item_t req;
    req.src_pixel = 24'($urandom);
    req.dst_pixel = 24'($urandom);
    req.last_in = ($urandom_range(7, 0) == 0);
    if ($urandom_range(9, 0) == 0)
      req.src_pixel = $urandom_range(1, 0) ? 24'hFFFFFF : 24'h000000;
    if ($urandom_range(9, 0) == 0)
      req.dst_pixel = $urandom_range(1, 0) ? 24'hFFFFFF : 24'h000000;
    // Pull channels under the key often enough that both outcomes are common.
    if (board.mode == MODE_KEY) begin
      for (int c = 0; c < NUM_CHAN; c++)
        if ($urandom_range(3, 0) != 0)
          req.src_pixel[c*8 +: 8] = 8'($urandom_range(board.key[c*8 +: 8], 0));
    end
    return req;
  endfunction

  task automatic run_random();
    blend_mode_t m;
    pix_fmt_t    f;
    logic [7:0]  a;
    logic [23:0] k;
    for (int p = 0; p < NUM_PHASES; p++) begin
      m = $urandom_range(1, 0) ? MODE_ALPHA : blend_mode_t'($urandom_range(3, 0));
      f = pix_fmt_t'($urandom_range(1, 0));
      case ($urandom_range(3, 0))
        0: a = alpha_corners[$urandom_range(10, 0)];
        1: a = $urandom_range(1, 0) ? ALPHA_FULL : 8'd0;
        default: a = 8'($urandom);
      endcase
      case ($urandom_range(4, 0))
        0: k = 24'h000000;
        1: k = 24'hFFFFFF;
        default: k = 24'($urandom);
      endcase
      configure(m, f, a, k);
      send_burst = ($urandom_range(3, 0) == 0);
      recv_burst = ($urandom_range(3, 0) == 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        // Now and then the sender holds off until the pipeline has emptied.
        if (i == PHASE_LEN / 2 && (p == 0 || $urandom_range(3, 0) == 0))
          drain();
        send_pixel(random_pixel());
      end
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_random();
    drain();
    repeat (PIPE_DEPTH + 4) @(negedge clk);
    if (board.errors == 0 && board.expected_pixels.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pbro_pkg.sv
hw/rtl/pbro_prep.sv
hw/rtl/pbro_mul.sv
hw/rtl/pbro_mix.sv
hw/rtl/pixel_blend_raster_op.sv
hw/rtl/pbro_checker.sv
tb/sv/testbench.sv
